// File: rtl/cdpm_pkg.sv
// ============================================================================
// cdpm_pkg - command danger pattern matcher shared definitions
// Transfer types, danger levels and the constant rule table.
// ============================================================================
package cdpm_pkg;

    localparam int MAX_PAT    = 19;
    localparam int TABLE_SIZE = 23;

    localparam logic [1:0] LVL_OK    = 2'd0;
    localparam logic [1:0] LVL_WARN  = 2'd1;
    localparam logic [1:0] LVL_BLOCK = 2'd2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [2:0] PREFIX_MAX = 3'd7;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [1:0] danger_level;
        logic [4:0] rule_number;
    } t_out_item;

    typedef struct packed {
        logic       shift;
        logic       started;
        logic [2:0] pos;
    } t_match_ctl;

    // text holds the pattern right aligned: byte 0 is the last character
    typedef struct packed {
        logic [MAX_PAT*8-1:0] text;
        logic [4:0]           len;
        logic                 at_start;
        logic [1:0]           level;
    } t_rule;

    localparam t_rule RULE_TABLE [TABLE_SIZE] = '{
        '{"rm -rf /",                          5'd8,  1'b0, LVL_WARN},
        '{"rm -rf /*",                         5'd9,  1'b0, LVL_WARN},
        '{"rm -fr /",                          5'd8,  1'b0, LVL_WARN},
        '{"dd if=/dev/zero",                   5'd15, 1'b0, LVL_WARN},
        '{"dd if=/dev/urandom",                5'd18, 1'b0, LVL_WARN},
        '{"mkfs.",                             5'd5,  1'b1, LVL_WARN},
        '{"fdisk",                             5'd5,  1'b1, LVL_WARN},
        '{"parted",                            5'd6,  1'b1, LVL_WARN},
        '{"wipefs",                            5'd6,  1'b1, LVL_WARN},
        '{"> /dev/sd",                         5'd9,  1'b0, LVL_WARN},
        '{"chmod -R 777 /",                    5'd14, 1'b0, LVL_WARN},
        '{"chown -R",                          5'd8,  1'b0, LVL_WARN},
        '{"chmod 777",                         5'd9,  1'b0, LVL_WARN},
        '{":(){ :|:& };:",                     5'd13, 1'b0, LVL_BLOCK},
        '{":(){ :|: &};:",                     5'd13, 1'b0, LVL_BLOCK},
        '{"shred /dev/",                       5'd11, 1'b0, LVL_WARN},
        '{"rm -rf ~",                          5'd8,  1'b0, LVL_WARN},
        '{"rm -rf $HOME",                      5'd12, 1'b0, LVL_WARN},
        '{"nc -e /bin/sh",                     5'd13, 1'b0, LVL_WARN},
        '{"nc -e /bin/bash",                   5'd15, 1'b0, LVL_WARN},
        '{"bash -i >& /dev/tcp",               5'd19, 1'b0, LVL_WARN},
        '{{"rm ~/.", 8'h6d, "ysh_history"},    5'd18, 1'b0, LVL_WARN},
        '{{"> ~/.", 8'h6d, "ysh_history"},     5'd17, 1'b0, LVL_WARN}
    };

endpackage

// File: rtl/cdpm_match.sv
// ============================================================================
// cdpm_match - parallel pattern compare
// Compares every rule against the newest window bytes in one pass.
// ============================================================================
module cdpm_match #(
    parameter int RULE_NUM = 23
) (
    input  logic [cdpm_pkg::MAX_PAT-1:0][7:0] i_window,
    input  cdpm_pkg::t_match_ctl              i_ctl,
    output logic [RULE_NUM-1:0]               o_hit
);
    import cdpm_pkg::*;

    logic [4:0] pos_len;

    assign pos_len = {2'b00, i_ctl.pos} + 5'd1;

    always_comb begin
        logic tail;
        for (int r = 0; r < RULE_NUM; r++) begin
            tail = 1'b1;
            for (int k = 0; k < MAX_PAT; k++) begin
                if ((5'(k) < RULE_TABLE[r].len) &&
                    (i_window[k] != RULE_TABLE[r].text[k*8 +: 8])) begin
                    tail = 1'b0;
                end
            end
            if (RULE_TABLE[r].at_start) begin
                o_hit[r] = i_ctl.shift && tail && i_ctl.started &&
                           (pos_len == RULE_TABLE[r].len);
            end else begin
                o_hit[r] = i_ctl.shift && tail;
            end
        end
    end

endmodule

// File: rtl/command_danger_pattern_matcher.sv
// ============================================================================
// command_danger_pattern_matcher - dangerous command line detector
// Byte-serial multi-pattern matcher with a per-line danger verdict.
// ============================================================================
// One command line byte is taken per cycle while input ready is high. Each
// byte is compared against all rules in the cycle of its transfer and the hits
// are registered in the compare stage; when that stage is not stalled, they are
// folded into the sticky per-rule flags and, on the final byte, the verdict is
// loaded into the output register. Input ready drops only while a finished
// line sits behind a result that has not been taken.
module command_danger_pattern_matcher #(
    parameter int WINDOW_DEPTH = 19,
    parameter int RULE_COUNT   = 23
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cdpm_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cdpm_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data
);
    import cdpm_pkg::*;

    localparam int ACTIVE = (RULE_COUNT < TABLE_SIZE) ? RULE_COUNT : TABLE_SIZE;

    logic [7:0]        r_window [WINDOW_DEPTH];
    logic [7:0]        n_window [WINDOW_DEPTH];
    logic              r_started;
    logic              n_started;
    logic [2:0]        r_prefix_count;
    logic [2:0]        n_prefix_count;
    logic              r_line_ended;
    logic              r_check_enable;

    logic              r_s1_valid;
    logic              r_s1_last;
    logic              r_s1_en;
    logic [ACTIVE-1:0] r_s1_hit;
    logic [ACTIVE-1:0] r_matched;
    logic [ACTIVE-1:0] merged;
    logic              r_out_valid;
    t_out_item         r_out_item;
    t_out_item         n_out_item;

    logic                       stall;
    logic                       in_fire;
    logic                       s2_fire;
    logic                       do_shift;
    t_match_ctl                 match_ctl;
    logic [MAX_PAT-1:0][7:0]    tail_window;
    logic [ACTIVE-1:0]          hit;

    assign stall      = r_s1_valid && r_s1_last && r_out_valid && !i_out_ready;
    assign o_in_ready = !stall;
    assign in_fire    = i_in_valid && o_in_ready;
    assign s2_fire    = r_s1_valid && !stall;

    assign do_shift = !r_line_ended && (i_in_item.char_byte != CHAR_NUL);

    always_comb begin
        n_window[0] = i_in_item.char_byte;
        for (int k = 1; k < WINDOW_DEPTH; k++) begin
            n_window[k] = r_window[k-1];
        end
        for (int k = 0; k < MAX_PAT; k++) begin
            tail_window[k] = n_window[k];
        end
        n_started      = r_started || (i_in_item.char_byte != CHAR_SPACE);
        n_prefix_count = r_prefix_count;
        if (n_started && (r_prefix_count != PREFIX_MAX)) begin
            n_prefix_count = r_prefix_count + 3'd1;
        end
    end

    assign match_ctl.shift   = do_shift;
    assign match_ctl.started = n_started;
    assign match_ctl.pos     = r_prefix_count;

    cdpm_match #(
        .RULE_NUM (ACTIVE)
    ) u_match (
        .i_window (tail_window),
        .i_ctl    (match_ctl),
        .o_hit    (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_check_enable <= i_cfg_data;
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_window[k] <= '0;
            end
            r_started      <= 1'b0;
            r_prefix_count <= '0;
            r_line_ended   <= 1'b0;
        end else if (in_fire) begin
            if (i_in_item.last_char) begin
                for (int k = 0; k < WINDOW_DEPTH; k++) begin
                    r_window[k] <= '0;
                end
                r_started      <= 1'b0;
                r_prefix_count <= '0;
                r_line_ended   <= 1'b0;
            end else if (do_shift) begin
                r_window       <= n_window;
                r_started      <= n_started;
                r_prefix_count <= n_prefix_count;
            end else begin
                r_line_ended   <= 1'b1;
            end
        end
    end

    // compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!stall) begin
            r_s1_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_last <= i_in_item.last_char;
            r_s1_en   <= r_check_enable;
            r_s1_hit  <= hit;
        end
    end

    // verdict
    assign merged = r_matched | r_s1_hit;

    always_comb begin
        logic       blk_found;
        logic       wrn_found;
        logic [4:0] blk_num;
        logic [4:0] wrn_num;
        blk_found = 1'b0;
        wrn_found = 1'b0;
        blk_num   = '0;
        wrn_num   = '0;
        for (int i = ACTIVE - 1; i >= 0; i--) begin
            if (merged[i] && (RULE_TABLE[i].level == LVL_BLOCK)) begin
                blk_found = 1'b1;
                blk_num   = 5'(i + 1);
            end
            if (merged[i] && (RULE_TABLE[i].level == LVL_WARN)) begin
                wrn_found = 1'b1;
                wrn_num   = 5'(i + 1);
            end
        end
        n_out_item.danger_level = LVL_OK;
        n_out_item.rule_number  = '0;
        if (r_s1_en && blk_found) begin
            n_out_item.danger_level = LVL_BLOCK;
            n_out_item.rule_number  = blk_num;
        end else if (r_s1_en && wrn_found) begin
            n_out_item.danger_level = LVL_WARN;
            n_out_item.rule_number  = wrn_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_fire) begin
                r_matched <= r_s1_last ? '0 : merged;
            end
            if (s2_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && r_s1_last) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: rtl/cdpm_checker.sv
// ============================================================================
// cdpm_checker - port-level checks for the pattern matcher
// Observes the top level ports only; attached by bind.
// ============================================================================
module cdpm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input cdpm_pkg::t_out_item o_out_item
);
    import cdpm_pkg::*;

    a_no_rule_iff_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_item.danger_level == LVL_OK) == (o_out_item.rule_number == 5'd0)))
        else $error("rule number does not agree with danger level");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_item.danger_level == LVL_OK) || (o_out_item.danger_level == LVL_WARN)
             || (o_out_item.danger_level == LVL_BLOCK))
            && (o_out_item.rule_number <= 5'(TABLE_SIZE)))
        else $error("result out of range");

    a_ready_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind command_danger_pattern_matcher cdpm_checker u_cdpm_checker (.*);
